// ===== design/jap_pkg.sv =====
// ---------------------------------------------------------------------------
// jap_pkg: shared codes for the job admission policy
// Action codes, decision reason codes and configuration register indexes.
// ---------------------------------------------------------------------------
package jap_pkg;

    localparam int ACTION_W  = 2;
    localparam int REASON_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int TIME_W    = 32;
    localparam int HOST_W    = 16;
    localparam int RAND_W    = 16;
    localparam int COUNT_W   = 7;

    localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_RESET  = 2'd3;

    localparam logic [REASON_W-1:0] RSN_DISABLED   = 3'd0;
    localparam logic [REASON_W-1:0] RSN_CONTROLLER = 3'd1;
    localparam logic [REASON_W-1:0] RSN_ZERO_TIME  = 3'd2;
    localparam logic [REASON_W-1:0] RSN_STREAK     = 3'd3;
    localparam logic [REASON_W-1:0] RSN_TIMEOUT    = 3'd4;
    localparam logic [REASON_W-1:0] RSN_DRAW_ACC   = 3'd5;
    localparam logic [REASON_W-1:0] RSN_DRAW_REJ   = 3'd6;
    localparam logic [REASON_W-1:0] RSN_NON_CHECK  = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TMO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_PEER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_COUNT = 3'd5;

endpackage

// ===== design/jap_ram.sv =====
// ---------------------------------------------------------------------------
// jap_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module jap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/job_admission_policy.sv =====
// ---------------------------------------------------------------------------
// job_admission_policy: probabilistic job admission
// Check, record, tick and reset-timer items against a job time history.
// ---------------------------------------------------------------------------
// Record, tick and reset-timer items, and checks settled without a window
// walk, pass straight from acceptance to ST_OUT, which loads the result. A
// check that draws against a nonempty window walks it through the single RAM
// read port, one entry per cycle, lets the last read drain, and then forms
// the products in ST_MULT and compares them in ST_CMP before ST_OUT.
// The input is ready only while no item is in progress; a finished result
// waits in the output register. The history RAM is not cleared after reset;
// only entries that were recorded are read.
// ---------------------------------------------------------------------------
module job_admission_policy
    import jap_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic [TIME_W-1:0]    s_time_required,
    input  logic [HOST_W-1:0]    s_host_id,
    input  logic [RAND_W-1:0]    s_random_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_accepted,
    output logic [REASON_W-1:0]  m_decision_reason,
    output logic [COUNT_W-1:0]   m_history_count
);

    localparam int ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int PROD_W = TIME_W + RAND_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_MULT,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic                enabled_reg, enabled_next;
    logic                ctrl_mode_reg, ctrl_mode_next;
    logic [7:0]          host_limit_reg, host_limit_next;
    logic [15:0]         idle_tmo_reg, idle_tmo_next;
    logic [7:0]          per_peer_reg, per_peer_next;
    logic [7:0]          peer_count_reg, peer_count_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [HOST_W-1:0]   prev_host_reg, prev_host_next;
    logic [7:0]          streak_reg, streak_next;
    logic [31:0]         idle_reg, idle_next;
    logic                m_valid_reg, m_valid_next;
    logic                pend_reg, pend_next;
    logic [FILL_W-1:0]   walk_cnt_reg, walk_cnt_next;
    logic [ADDR_W-1:0]   walk_addr_reg, walk_addr_next;
    logic [TIME_W-1:0]   t_reg, t_next;
    logic [RAND_W-1:0]   rnd_reg, rnd_next;
    logic [TIME_W-1:0]   min_reg, min_next;
    logic [PROD_W-1:0]   lhs_reg, lhs_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic                acc_reg, acc_next;
    logic [REASON_W-1:0] reason_reg, reason_next;
    logic                m_acc_reg, m_acc_next;
    logic [REASON_W-1:0] m_reason_reg, m_reason_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic                accept;
    logic                ram_we;
    logic                ram_re;
    logic [TIME_W-1:0]   ram_rdata;
    logic [15:0]         lim_raw;
    logic [FILL_W-1:0]   lim;
    logic [FILL_W-1:0]   fill_inc;
    logic [7:0]          streak_upd;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign ram_we  = accept && (s_action == ACT_RECORD);
    assign ram_re  = (state_reg == ST_WALK) && (walk_cnt_reg != '0);

    jap_ram #(
        .WIDTH (TIME_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (head_reg),
        .wr_data (s_time_required),
        .rd_en   (ram_re),
        .rd_addr (walk_addr_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        lim_raw = {8'd0, peer_count_reg} * {8'd0, per_peer_reg};
        if (lim_raw == 16'd0) begin
            lim = FILL_W'(1);
        end else if (lim_raw >= 16'(HISTORY_DEPTH)) begin
            lim = FILL_W'(HISTORY_DEPTH);
        end else begin
            lim = FILL_W'(lim_raw);
        end
        fill_inc = (fill_reg < FILL_W'(HISTORY_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
        if (prev_host_reg == s_host_id) begin
            streak_upd = (streak_reg == 8'hFF) ? streak_reg : streak_reg + 8'd1;
        end else begin
            streak_upd = 8'd0;
        end
    end

    always_comb begin
        state_next      = state_reg;
        enabled_next    = enabled_reg;
        ctrl_mode_next  = ctrl_mode_reg;
        host_limit_next = host_limit_reg;
        idle_tmo_next   = idle_tmo_reg;
        per_peer_next   = per_peer_reg;
        peer_count_next = peer_count_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        prev_host_next  = prev_host_reg;
        streak_next     = streak_reg;
        idle_next       = idle_reg;
        m_valid_next    = m_valid_reg;
        pend_next       = 1'b0;
        walk_cnt_next   = walk_cnt_reg;
        walk_addr_next  = walk_addr_reg;
        t_next          = t_reg;
        rnd_next        = rnd_reg;
        min_next        = min_reg;
        lhs_next        = lhs_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        reason_next     = reason_reg;
        m_acc_next      = m_acc_reg;
        m_reason_next   = m_reason_reg;
        m_count_next    = m_count_reg;

        if (cfg_we) begin
            case (cfg_index)
                CFG_ENABLED:    enabled_next    = cfg_wdata[0];
                CFG_CONTROLLER: ctrl_mode_next  = cfg_wdata[0];
                CFG_HOST_LIMIT: host_limit_next = cfg_wdata[7:0];
                CFG_IDLE_TMO:   idle_tmo_next   = cfg_wdata;
                CFG_PER_PEER:   per_peer_next   = cfg_wdata[7:0];
                CFG_PEER_COUNT: peer_count_next = cfg_wdata[7:0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    t_next      = s_time_required;
                    rnd_next    = s_random_value;
                    acc_next    = 1'b0;
                    reason_next = RSN_NON_CHECK;
                    state_next  = ST_OUT;
                    case (s_action)
                        ACT_CHECK: begin
                            acc_next = 1'b1;
                            if (!enabled_reg) begin
                                reason_next = RSN_DISABLED;
                            end else if (ctrl_mode_reg) begin
                                reason_next = RSN_CONTROLLER;
                            end else if (s_time_required == '0) begin
                                reason_next = RSN_ZERO_TIME;
                            end else begin
                                prev_host_next = s_host_id;
                                if (streak_upd >= host_limit_reg) begin
                                    streak_next = 8'd0;
                                    reason_next = RSN_STREAK;
                                end else begin
                                    streak_next = streak_upd;
                                    if (idle_reg > {16'd0, idle_tmo_reg}) begin
                                        reason_next = RSN_TIMEOUT;
                                    end else if (fill_reg == '0) begin
                                        acc_next    = (s_random_value != '1);
                                        reason_next = (s_random_value != '1) ?
                                                      RSN_DRAW_ACC : RSN_DRAW_REJ;
                                    end else begin
                                        min_next       = '1;
                                        walk_cnt_next  = fill_reg;
                                        walk_addr_next = (head_reg == '0) ?
                                                         ADDR_W'(HISTORY_DEPTH - 1) :
                                                         head_reg - 1'b1;
                                        state_next     = ST_WALK;
                                    end
                                end
                            end
                        end
                        ACT_RECORD: begin
                            head_next = (head_reg == ADDR_W'(HISTORY_DEPTH - 1)) ?
                                        '0 : head_reg + 1'b1;
                            fill_next = (fill_inc > lim) ? lim : fill_inc;
                            idle_next = '0;
                        end
                        ACT_TICK: begin
                            if (idle_reg != '1) begin
                                idle_next = idle_reg + 32'd1;
                            end
                        end
                        default: begin
                            idle_next      = '0;
                            prev_host_next = '0;
                            streak_next    = 8'd0;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (pend_reg && (ram_rdata < min_reg)) begin
                    min_next = ram_rdata;
                end
                if (walk_cnt_reg != '0) begin
                    pend_next      = 1'b1;
                    walk_cnt_next  = walk_cnt_reg - 1'b1;
                    walk_addr_next = (walk_addr_reg == '0) ?
                                     ADDR_W'(HISTORY_DEPTH - 1) : walk_addr_reg - 1'b1;
                end else if (!pend_reg) begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                prod_next  = rnd_reg * t_reg;
                lhs_next   = {min_reg, {RAND_W{1'b0}}} - {{RAND_W{1'b0}}, min_reg};
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (min_reg >= t_reg) begin
                    acc_next = (rnd_reg != '1);
                end else begin
                    acc_next = (lhs_reg > prod_reg);
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                reason_next = acc_reg ? RSN_DRAW_ACC : RSN_DRAW_REJ;
                if (reason_reg != RSN_DRAW_ACC && reason_reg != RSN_DRAW_REJ) begin
                    reason_next = reason_reg;
                end
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_acc_next    = acc_reg;
                    m_reason_next = reason_reg;
                    m_count_next  = COUNT_W'(fill_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_CMP) begin
            reason_next = ((min_reg >= t_reg) ? (rnd_reg != '1) : (lhs_reg > prod_reg)) ?
                          RSN_DRAW_ACC : RSN_DRAW_REJ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            enabled_reg    <= 1'b0;
            ctrl_mode_reg  <= 1'b0;
            host_limit_reg <= 8'd5;
            idle_tmo_reg   <= 16'd10;
            per_peer_reg   <= 8'd2;
            peer_count_reg <= 8'd1;
            head_reg       <= '0;
            fill_reg       <= '0;
            prev_host_reg  <= '0;
            streak_reg     <= 8'd0;
            idle_reg       <= '0;
            m_valid_reg    <= 1'b0;
            pend_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            enabled_reg    <= enabled_next;
            ctrl_mode_reg  <= ctrl_mode_next;
            host_limit_reg <= host_limit_next;
            idle_tmo_reg   <= idle_tmo_next;
            per_peer_reg   <= per_peer_next;
            peer_count_reg <= peer_count_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            prev_host_reg  <= prev_host_next;
            streak_reg     <= streak_next;
            idle_reg       <= idle_next;
            m_valid_reg    <= m_valid_next;
            pend_reg       <= pend_next;
        end
        walk_cnt_reg  <= walk_cnt_next;
        walk_addr_reg <= walk_addr_next;
        t_reg         <= t_next;
        rnd_reg       <= rnd_next;
        min_reg       <= min_next;
        lhs_reg       <= lhs_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        reason_reg    <= reason_next;
        m_acc_reg     <= m_acc_next;
        m_reason_reg  <= m_reason_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_accepted        = m_acc_reg;
    assign m_decision_reason = m_reason_reg;
    assign m_history_count   = m_count_reg;

endmodule
